### design/svf_pkg.sv
package svf_pkg;

   // Integrator states and the two bandpass/lowpass taps
   localparam int STATE_W  = 32;
   // Damped bandpass term k*v1 is clamped to this width
   localparam int KV_W     = 48;
   // Internal highpass value x - k*v1 - v2
   localparam int HP_W     = 50;
   // Value operand of the shared multiplier (holds x - s2 with room to spare)
   localparam int VAL_W    = STATE_W + 2;
   // The highpass value goes through the multiplier in two halves split here
   localparam int HP_SPLIT = VAL_W - 1;
   // Rounded accumulator width, and the width used for every clamp
   localparam int RND_W    = HP_W + 9;
   localparam int SAT_W    = RND_W + 1;
   localparam int CFG_IDX_W = 3;

   localparam logic [CFG_IDX_W-1:0] REG_COEF_A1  = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_COEF_A2  = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_COEF_A3  = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_DAMPING  = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_MIX_HIGH = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_MIX_BAND = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_MIX_LOW  = 3'd6;

   typedef enum logic [3:0] {
      OP_A1_S1,
      OP_A2_D,
      OP_A2_S1,
      OP_A3_D,
      OP_K_V1,
      OP_MB_V1,
      OP_ML_V2,
      OP_MH_HPLO,
      OP_MH_HPHI
   } op_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_ADD_HI
   } acc_mode_type;

   typedef struct packed {
      op_sel_type   op_sel;
      acc_mode_type acc_mode;
      logic         ld_v1;
      logic         ld_v2;
      logic         ld_kv1;
      logic         ld_hp;
      logic         finish;
   } svf_ctrl_type;

endpackage

### design/svf_mac.sv
module svf_mac
   import svf_pkg::*;
#(
   parameter int COEF_WIDTH = 32
) (
   input  logic                             clock,
   input  logic signed [COEF_WIDTH-1:0]     op_coef,
   input  logic signed [VAL_W-1:0]          op_val,
   input  acc_mode_type                     acc_mode,
   output logic signed [COEF_WIDTH+HP_W:0]  acc
);

   localparam int PROD_W = COEF_WIDTH + VAL_W;
   localparam int ACC_W  = COEF_WIDTH + HP_W + 1;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  prod_ext;

   assign prod_in  = op_coef * op_val;
   assign prod_ext = ACC_W'(prod_ff);

   always_comb begin
      case (acc_mode)
         ACC_HOLD:   acc_in = acc_ff;
         ACC_LOAD:   acc_in = prod_ext;
         ACC_ADD:    acc_in = acc_ff + prod_ext;
         // upper half of a split operand: weight the product accordingly
         ACC_ADD_HI: acc_in = acc_ff + (prod_ext <<< HP_SPLIT);
         default:    acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

### design/svf_seq.sv
module svf_seq
   import svf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         out_free,
   output svf_ctrl_type ctrl,
   output logic         busy
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_A1S1,
      S_A2D,
      S_A2S1,
      S_A3D,
      S_KV1,
      S_MBV1,
      S_MLV2,
      S_HP,
      S_MHLO,
      S_MHHI,
      S_ACCHI,
      S_DONE
   } seq_state_type;

   seq_state_type state_ff;
   seq_state_type state_in;

   always_comb begin
      ctrl          = '0;
      ctrl.op_sel   = OP_A1_S1;
      ctrl.acc_mode = ACC_HOLD;
      state_in      = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_A1S1;
         end
         S_A1S1: begin
            ctrl.op_sel = OP_A1_S1;
            state_in    = S_A2D;
         end
         S_A2D: begin
            ctrl.op_sel   = OP_A2_D;
            ctrl.acc_mode = ACC_LOAD;
            state_in      = S_A2S1;
         end
         S_A2S1: begin
            ctrl.op_sel   = OP_A2_S1;
            ctrl.acc_mode = ACC_ADD;
            state_in      = S_A3D;
         end
         S_A3D: begin
            // accumulator holds a1*s1 + a2*d here
            ctrl.op_sel   = OP_A3_D;
            ctrl.acc_mode = ACC_LOAD;
            ctrl.ld_v1    = 1'b1;
            state_in      = S_KV1;
         end
         S_KV1: begin
            ctrl.op_sel   = OP_K_V1;
            ctrl.acc_mode = ACC_ADD;
            state_in      = S_MBV1;
         end
         S_MBV1: begin
            ctrl.op_sel   = OP_MB_V1;
            ctrl.acc_mode = ACC_LOAD;
            ctrl.ld_v2    = 1'b1;
            state_in      = S_MLV2;
         end
         S_MLV2: begin
            ctrl.op_sel   = OP_ML_V2;
            ctrl.acc_mode = ACC_LOAD;
            ctrl.ld_kv1   = 1'b1;
            state_in      = S_HP;
         end
         S_HP: begin
            // multiplier idles while the highpass value is formed
            ctrl.acc_mode = ACC_ADD;
            ctrl.ld_hp    = 1'b1;
            state_in      = S_MHLO;
         end
         S_MHLO: begin
            ctrl.op_sel = OP_MH_HPLO;
            state_in    = S_MHHI;
         end
         S_MHHI: begin
            ctrl.op_sel   = OP_MH_HPHI;
            ctrl.acc_mode = ACC_ADD;
            state_in      = S_ACCHI;
         end
         S_ACCHI: begin
            ctrl.op_sel   = OP_MH_HPHI;
            ctrl.acc_mode = ACC_ADD_HI;
            state_in      = S_DONE;
         end
         S_DONE: begin
            // hold until the output register can take the result
            ctrl.finish = 1'b1;
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### design/state_variable_filter.sv
// Trapezoidal state variable filter. Each request carries one signed sample and
// produces one result holding the mode mix, lowpass, bandpass and highpass taps,
// each saturated to the sample width. All nine coefficient products go through
// one shared multiplier-accumulator (the highpass product in two halves), so
// a new request is taken only once the result of the last one has been
// offered; req_tready is low during reset and while a sample is in work, and
// stays low at the end while an earlier
// result is still waiting to be taken. Coefficients and mix gains are signed
// Q8.24 by default (COEF_WIDTH-8 fraction bits) and are written through the csr
// port, which is ready whenever reset is low; write them only while no sample
// is in work. Register indexes: 0 a1, 1 a2, 2 a3, 3 damping, 4 mix_high,
// 5 mix_band, 6 mix_low; index 7 is ignored. The two integrator states are
// 32-bit and saturate.
module state_variable_filter
   import svf_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 24,
   parameter int COEF_WIDTH   = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // sample_in
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // mixed_out, low_out, band_out, high_out
   output logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0]       rsp_tdata,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [CFG_IDX_W-1:0]                      csr_index,
   input  logic [COEF_WIDTH-1:0]                     csr_data
);

   localparam int COEF_FRAC = COEF_WIDTH - 8;
   localparam int ACC_W     = COEF_WIDTH + HP_W + 1;
   localparam int RSP_W     = ((4*SAMPLE_WIDTH+7)/8)*8;
   localparam int OUT_W     = 4*SAMPLE_WIDTH;

   localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
      {7'b0, 1'b1, {COEF_FRAC{1'b0}}};
   localparam logic signed [ACC_W-1:0] RND_HALF =
      {{(ACC_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};

   localparam logic signed [SAT_W-1:0] S32_MAX =
      {{(SAT_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
   localparam logic signed [SAT_W-1:0] S32_MIN =
      {{(SAT_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};
   localparam logic signed [SAT_W-1:0] S48_MAX =
      {{(SAT_W-KV_W+1){1'b0}}, {(KV_W-1){1'b1}}};
   localparam logic signed [SAT_W-1:0] S48_MIN =
      {{(SAT_W-KV_W+1){1'b1}}, {(KV_W-1){1'b0}}};
   localparam logic signed [SAT_W-1:0] SW_MAX =
      {{(SAT_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAT_W-1:0] SW_MIN =
      {{(SAT_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

   function automatic logic signed [SAT_W-1:0] clamp(
      input logic signed [SAT_W-1:0] v,
      input logic signed [SAT_W-1:0] lo,
      input logic signed [SAT_W-1:0] hi
   );
      logic signed [SAT_W-1:0] r;
      if (v > hi) begin
         r = hi;
      end else if (v < lo) begin
         r = lo;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // configuration registers
   logic signed [COEF_WIDTH-1:0] coef_a1_ff, coef_a2_ff, coef_a3_ff, damping_ff;
   logic signed [COEF_WIDTH-1:0] mix_high_ff, mix_band_ff, mix_low_ff;

   // integrators and per-sample working values
   logic signed [STATE_W-1:0]      integrator_one_ff, integrator_two_ff;
   logic signed [STATE_W-1:0]      integrator_one_in, integrator_two_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic signed [STATE_W:0]        diff_ff, diff_in;
   logic signed [STATE_W-1:0]      v1_ff, v1_in, v2_ff, v2_in;
   logic signed [KV_W-1:0]         kv1_ff, kv1_in;
   logic signed [HP_W-1:0]         hp_ff, hp_in;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]               rsp_data_ff, rsp_data_in;

   svf_ctrl_type                   ctrl;
   logic                           busy;
   logic                           accept;
   logic                           out_free;
   logic                           fin_go;

   logic signed [COEF_WIDTH-1:0]   op_coef;
   logic signed [VAL_W-1:0]        op_val;
   logic signed [ACC_W-1:0]        acc;
   logic signed [ACC_W-1:0]        acc_rnd;
   logic signed [RND_W-1:0]        rnd;
   logic signed [SAT_W-1:0]        v1_sat, v2_sat, kv1_sat, mixed_sat;
   logic signed [SAT_W-1:0]        s1_sat, s2_sat;
   logic signed [SAT_W-1:0]        low_sat, band_sat, high_sat;
   logic signed [HP_W-HP_SPLIT-1:0] hp_hi;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !busy && !reset;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fin_go     = ctrl.finish && out_free;
   assign csr_ready  = !reset;

   svf_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .out_free (out_free),
      .ctrl     (ctrl),
      .busy     (busy)
   );

   assign hp_hi = $signed(hp_ff[HP_W-1:HP_SPLIT]);

   always_comb begin
      case (ctrl.op_sel)
         OP_A1_S1: begin
            op_coef = coef_a1_ff;
            op_val  = VAL_W'(integrator_one_ff);
         end
         OP_A2_D: begin
            op_coef = coef_a2_ff;
            op_val  = VAL_W'(diff_ff);
         end
         OP_A2_S1: begin
            op_coef = coef_a2_ff;
            op_val  = VAL_W'(integrator_one_ff);
         end
         OP_A3_D: begin
            op_coef = coef_a3_ff;
            op_val  = VAL_W'(diff_ff);
         end
         OP_K_V1: begin
            op_coef = damping_ff;
            op_val  = VAL_W'(v1_ff);
         end
         OP_MB_V1: begin
            op_coef = mix_band_ff;
            op_val  = VAL_W'(v1_ff);
         end
         OP_ML_V2: begin
            op_coef = mix_low_ff;
            op_val  = VAL_W'(v2_ff);
         end
         OP_MH_HPLO: begin
            op_coef = mix_high_ff;
            op_val  = $signed({1'b0, hp_ff[HP_SPLIT-1:0]});
         end
         OP_MH_HPHI: begin
            op_coef = mix_high_ff;
            op_val  = VAL_W'(hp_hi);
         end
         default: begin
            op_coef = coef_a1_ff;
            op_val  = VAL_W'(integrator_one_ff);
         end
      endcase
   end

   svf_mac #(
      .COEF_WIDTH (COEF_WIDTH)
   ) u_mac (
      .clock    (clock),
      .op_coef  (op_coef),
      .op_val   (op_val),
      .acc_mode (ctrl.acc_mode),
      .acc      (acc)
   );

   // round half up, then drop the fraction bits
   assign acc_rnd = acc + RND_HALF;
   assign rnd     = $signed(acc_rnd[ACC_W-1:COEF_FRAC]);

   assign v1_sat    = clamp(SAT_W'(rnd), S32_MIN, S32_MAX);
   assign v2_sat    = clamp(SAT_W'(rnd) + SAT_W'(integrator_two_ff), S32_MIN, S32_MAX);
   assign kv1_sat   = clamp(SAT_W'(rnd), S48_MIN, S48_MAX);
   assign mixed_sat = clamp(SAT_W'(rnd), SW_MIN, SW_MAX);

   assign v1_in  = v1_sat[STATE_W-1:0];
   assign v2_in  = v2_sat[STATE_W-1:0];
   assign kv1_in = kv1_sat[KV_W-1:0];
   assign hp_in  = HP_W'(sample_ff) - HP_W'(kv1_ff) - HP_W'(v2_ff);

   assign sample_in = $signed(req_tdata[SAMPLE_WIDTH-1:0]);
   assign diff_in   = (STATE_W+1)'(sample_in) - (STATE_W+1)'(integrator_two_ff);

   assign s1_sat = clamp((SAT_W'(v1_ff) <<< 1) - SAT_W'(integrator_one_ff), S32_MIN, S32_MAX);
   assign s2_sat = clamp((SAT_W'(v2_ff) <<< 1) - SAT_W'(integrator_two_ff), S32_MIN, S32_MAX);
   assign integrator_one_in = s1_sat[STATE_W-1:0];
   assign integrator_two_in = s2_sat[STATE_W-1:0];

   assign low_sat  = clamp(SAT_W'(v2_ff), SW_MIN, SW_MAX);
   assign band_sat = clamp(SAT_W'(v1_ff), SW_MIN, SW_MAX);
   assign high_sat = clamp(SAT_W'(hp_ff), SW_MIN, SW_MAX);

   assign rsp_data_in = {high_sat[SAMPLE_WIDTH-1:0], band_sat[SAMPLE_WIDTH-1:0],
                         low_sat[SAMPLE_WIDTH-1:0], mixed_sat[SAMPLE_WIDTH-1:0]};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fin_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state, configuration and integrators
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff      <= 1'b0;
         coef_a1_ff        <= COEF_ONE;
         coef_a2_ff        <= '0;
         coef_a3_ff        <= '0;
         damping_ff        <= COEF_ONE;
         mix_high_ff       <= COEF_ONE;
         mix_band_ff       <= '0;
         mix_low_ff        <= '0;
         integrator_one_ff <= '0;
         integrator_two_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_COEF_A1:  coef_a1_ff  <= csr_data;
               REG_COEF_A2:  coef_a2_ff  <= csr_data;
               REG_COEF_A3:  coef_a3_ff  <= csr_data;
               REG_DAMPING:  damping_ff  <= csr_data;
               REG_MIX_HIGH: mix_high_ff <= csr_data;
               REG_MIX_BAND: mix_band_ff <= csr_data;
               REG_MIX_LOW:  mix_low_ff  <= csr_data;
               default: ;
            endcase
         end
         if (fin_go) begin
            integrator_one_ff <= integrator_one_in;
            integrator_two_ff <= integrator_two_in;
         end
      end
   end

   // working values
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= sample_in;
         diff_ff   <= diff_in;
      end
      if (ctrl.ld_v1)  v1_ff  <= v1_in;
      if (ctrl.ld_v2)  v2_ff  <= v2_in;
      if (ctrl.ld_kv1) kv1_ff <= kv1_in;
      if (ctrl.ld_hp)  hp_ff  <= hp_in;
      if (fin_go)      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request accepted but sequencer not busy");

   a_result_after_finish: assert property (@(posedge clock) disable iff (reset)
      fin_go |=> rsp_tvalid)
      else $error("finished request did not reach the output register");

   a_state_only_on_finish: assert property (@(posedge clock) disable iff (reset)
      !fin_go |=> ($stable(integrator_one_ff) && $stable(integrator_two_ff)))
      else $error("integrator state changed outside the final step");
`endif

endmodule

### verif/svf_tap_check.sv
`timescale 1ns / 100ps

module svf_tap_check
   import svf_pkg::*;
#(
   parameter int SW = 24,
   parameter int CW = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // sample_in
   input  logic [((SW+7)/8)*8-1:0]         req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // mixed_out, low_out, band_out, high_out
   input  logic [((4*SW+7)/8)*8-1:0]       rsp_tdata,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [CFG_IDX_W-1:0]            csr_index,
   input  logic [CW-1:0]                   csr_data,
   output int                              mismatch_count,
   output int                              taps_waiting
);

   localparam int FRAC     = CW - 8;
   localparam int STATE_BW = 32;
   localparam int KV_BW    = 48;

   typedef logic signed [127:0] acc_type;

   typedef struct {
      logic [SW-1:0] mixed;
      logic [SW-1:0] low;
      logic [SW-1:0] band;
      logic [SW-1:0] high;
   } taps_type;

   taps_type taps_due[$];

   logic signed [CW-1:0] a1, a2, a3, k_damp, g_high, g_band, g_low;
   logic signed [STATE_BW-1:0] integ_one, integ_two;

   // round half up, then drop the fraction bits
   function automatic acc_type round_q(input acc_type v);
      return (v + (acc_type'(1) <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic acc_type clamp(input acc_type v, input int bits);
      acc_type top_v, bot_v;
      top_v = (acc_type'(1) <<< (bits - 1)) - 1;
      bot_v = -top_v - 1;
      if (v > top_v) return top_v;
      if (v < bot_v) return bot_v;
      return v;
   endfunction

   task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] value);
      case (idx)
         REG_COEF_A1:  a1 = value;
         REG_COEF_A2:  a2 = value;
         REG_COEF_A3:  a3 = value;
         REG_DAMPING:  k_damp = value;
         REG_MIX_HIGH: g_high = value;
         REG_MIX_BAND: g_band = value;
         REG_MIX_LOW:  g_low = value;
         default: ;
      endcase
   endtask

   task automatic predict_taps(input logic signed [SW-1:0] sample);
      acc_type x, s1, s2, d, v1, v2, kv1, hp, mix;
      taps_type due;
      x  = acc_type'(sample);
      s1 = acc_type'(integ_one);
      s2 = acc_type'(integ_two);
      d  = x - s2;
      v1 = clamp(round_q(acc_type'(a1) * s1 + acc_type'(a2) * d), STATE_BW);
      v2 = clamp(s2 + round_q(acc_type'(a2) * s1 + acc_type'(a3) * d), STATE_BW);
      integ_one = STATE_BW'(clamp(2 * v1 - s1, STATE_BW));
      integ_two = STATE_BW'(clamp(2 * v2 - s2, STATE_BW));
      kv1 = clamp(round_q(acc_type'(k_damp) * v1), KV_BW);
      // the mix takes the unclamped highpass value
      hp  = x - kv1 - v2;
      mix = round_q(acc_type'(g_high) * hp + acc_type'(g_band) * v1
                    + acc_type'(g_low) * v2);
      due.mixed = SW'(clamp(mix, SW));
      due.low   = SW'(clamp(v2, SW));
      due.band  = SW'(clamp(v1, SW));
      due.high  = SW'(clamp(hp, SW));
      taps_due.push_back(due);
   endtask

   task automatic match_field(input string name, input logic [SW-1:0] want,
                              input logic [SW-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         mismatch_count++;
      end
   endtask

   task automatic check_taps(input logic [((4*SW+7)/8)*8-1:0] data);
      taps_type want;
      if (taps_due.size() == 0) begin
         $error("result accepted with no request outstanding");
         mismatch_count++;
      end else begin
         want = taps_due.pop_front();
         match_field("mixed_out", want.mixed, data[SW-1:0]);
         match_field("low_out",   want.low,   data[2*SW-1:SW]);
         match_field("band_out",  want.band,  data[3*SW-1:2*SW]);
         match_field("high_out",  want.high,  data[4*SW-1:3*SW]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         a1        = CW'(1) << FRAC;
         a2        = '0;
         a3        = '0;
         k_damp    = CW'(1) << FRAC;
         g_high    = CW'(1) << FRAC;
         g_band    = '0;
         g_low     = '0;
         integ_one = '0;
         integ_two = '0;
         taps_due.delete();
      end else begin
         if (csr_valid && csr_ready)
            apply_write(csr_index, csr_data);
         // retire the oldest result before queueing the new request
         if (rsp_tvalid && rsp_tready)
            check_taps(rsp_tdata);
         if (req_tvalid && req_tready)
            predict_taps(req_tdata[SW-1:0]);
      end
      taps_waiting = taps_due.size();
   end

endmodule

### verif/state_variable_filter_tb.sv
`timescale 1ns / 100ps

module state_variable_filter_tb;
   import svf_pkg::*;

   localparam int SW          = 24;
   localparam int CW          = 32;
   localparam int REQ_W       = ((SW+7)/8)*8;
   localparam int RSP_W       = ((4*SW+7)/8)*8;
   localparam int STALL_LIMIT = 2000;
   localparam int ITEM_TARGET = 1650;
   localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
   localparam logic [CW-1:0] Q_ONE     = 32'h0100_0000;
   localparam logic [CW-1:0] Q_NEG_ONE = 32'hFF00_0000;
   localparam logic [CW-1:0] Q_MAX     = 32'h7FFF_FFFF;
   localparam logic [CW-1:0] Q_MIN     = 32'h8000_0000;
   localparam logic [SW-1:0] S_MAX     = 24'h7F_FFFF;
   localparam logic [SW-1:0] S_MIN     = 24'h80_0000;

   typedef struct {
      logic [CW-1:0] a1, a2, a3, k, high, band, low;
   } coef_bank_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CFG_IDX_W-1:0] csr_index = '0;
   logic [CW-1:0] csr_data = '0;

   int mismatch_count;
   int taps_waiting;
   int stall_cycles = 0;
   bit quiet = 1'b0;

   always #6 clock = ~clock;

   state_variable_filter #(.SAMPLE_WIDTH(SW), .COEF_WIDTH(CW)) dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   svf_tap_check #(.SW(SW), .CW(CW)) tap_check (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .mismatch_count, .taps_waiting
   );

   // result side back-pressure
   always @(negedge clock) begin
      rsp_tready <= quiet || ($urandom_range(0, 99) >= 15);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   function automatic logic [CW-1:0] to_q(input real r);
      logic [CW-1:0] v;
      v = $rtoi(r * 16777216.0);
      return v;
   endfunction

   function automatic logic [CW-1:0] edge_coef();
      case ($urandom_range(0, 4))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return '0;
         3: return Q_ONE;
         default: return Q_NEG_ONE;
      endcase
   endfunction

   function automatic logic [SW-1:0] edge_sample();
      case ($urandom_range(0, 3))
         0: return S_MAX;
         1: return S_MIN;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   function automatic logic [SW-1:0] rand_sample();
      logic [31:0] r;
      logic signed [SW-1:0] v;
      r = $urandom;
      v = r[SW-1:0];
      case ($urandom_range(0, 9))
         0: return edge_sample();
         1, 2: return v;
         default: return v >>> $urandom_range(0, 20);
      endcase
   endfunction

   // a stable filter from random cutoff and damping, gains in half steps
   function automatic coef_bank_type tuned_bank();
      real g, kd, c1;
      coef_bank_type b;
      g  = 0.005 + $urandom_range(0, 3000) / 1000.0;
      kd = 0.05 + $urandom_range(0, 1950) / 1000.0;
      c1 = 1.0 / (1.0 + g * (g + kd));
      b.a1   = to_q(c1);
      b.a2   = to_q(g * c1);
      b.a3   = to_q(g * g * c1);
      b.k    = to_q(kd);
      b.high = to_q(($itor($urandom_range(0, 8)) - 4.0) * 0.5);
      b.band = to_q(($itor($urandom_range(0, 8)) - 4.0) * 0.5);
      b.low  = to_q(($itor($urandom_range(0, 8)) - 4.0) * 0.5);
      return b;
   endfunction

   task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic program_coefs(input coef_bank_type b);
      put_reg(REG_COEF_A1, b.a1);
      put_reg(REG_COEF_A2, b.a2);
      put_reg(REG_COEF_A3, b.a3);
      put_reg(REG_DAMPING, b.k);
      put_reg(REG_MIX_HIGH, b.high);
      put_reg(REG_MIX_BAND, b.band);
      put_reg(REG_MIX_LOW, b.low);
      // unmapped index, must leave everything alone
      put_reg(REG_SPARE, $urandom);
      csr_valid <= 1'b0;
   endtask

   task automatic send_sample(input logic [SW-1:0] x);
      while (!quiet && $urandom_range(0, 99) < 15) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(x);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // hold off the sender until every result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (taps_waiting != 0) @(negedge clock);
      @(negedge clock);
   endtask

   initial begin
      coef_bank_type bank;
      int sent, phase, n;
      bit tone;
      real amp, ph, step_r;
      logic signed [SW-1:0] s;

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset coefficients: passthrough on the highpass tap
      send_sample(S_MAX);
      send_sample(S_MIN);
      send_sample('0);
      send_sample('1);
      send_sample(SW'(1));
      send_sample(24'h55_5555);
      send_sample(24'hAA_AAAA);
      drain();

      // moderate filter, all three taps mixed: step up and down at full scale
      bank.a1 = to_q(1.0 / 1.75);
      bank.a2 = to_q(0.5 / 1.75);
      bank.a3 = to_q(0.25 / 1.75);
      bank.k = Q_ONE;
      bank.high = Q_ONE;
      bank.band = Q_ONE;
      bank.low = Q_ONE;
      program_coefs(bank);
      repeat (4) send_sample(S_MAX);
      repeat (4) send_sample(S_MIN);
      drain();

      // extreme coefficients drive the states and outputs into saturation
      bank.a1 = Q_MAX;
      bank.a2 = Q_MAX;
      bank.a3 = Q_MIN;
      bank.k = Q_MIN;
      bank.high = Q_MAX;
      bank.band = Q_MIN;
      bank.low = Q_MAX;
      program_coefs(bank);
      send_sample(S_MAX);
      send_sample(S_MIN);
      send_sample(S_MAX);
      send_sample(S_MIN);
      send_sample('0);
      drain();

      sent = 0;
      phase = 0;
      while (sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            7, 8: begin
               bank.a1 = edge_coef();
               bank.a2 = edge_coef();
               bank.a3 = edge_coef();
               bank.k = edge_coef();
               bank.high = edge_coef();
               bank.band = edge_coef();
               bank.low = edge_coef();
            end
            9: begin
               bank.a1 = $urandom;
               bank.a2 = $urandom;
               bank.a3 = $urandom;
               bank.k = $urandom;
               bank.high = $urandom;
               bank.band = $urandom;
               bank.low = $urandom;
            end
            default: bank = tuned_bank();
         endcase
         quiet = (phase == 3);
         program_coefs(bank);
         tone = ($urandom_range(0, 1) != 0);
         amp = $itor($urandom_range(1000, 8388607));
         step_r = $urandom_range(1, 1500) / 1000.0;
         ph = 0.0;
         n = $urandom_range(40, 140);
         for (int i = 0; i < n; i++) begin
            if (i == n / 2 && phase % 2 == 0)
               drain();
            if (tone) begin
               s = SW'($rtoi(amp * $sin(ph)));
               ph = ph + step_r;
            end else begin
               s = rand_sample();
            end
            send_sample(s);
            sent++;
         end
         drain();
         phase++;
      end
      quiet = 1'b0;

      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && taps_waiting == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
